FILE: hw/rtl/swd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swd_pkg
// Types, codes and CRC-32 helpers shared by the sync word packet deframer.
// ----------------------------------------------------------------------------
package swd_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [63:0] SyncWord  = 64'hDEAD_BEEF_CAFE_BABE;
  localparam logic [31:0] CrcInit   = 32'hFFFF_FFFF;
  localparam logic [31:0] CrcPoly   = 32'hEDB8_8320;
  localparam logic [15:0] CrcBytes  = 16'd4;

  typedef enum logic [2:0] {
    KIND_HEADER  = 3'd0,
    KIND_PAYLOAD = 3'd1,
    KIND_GOOD    = 3'd2,
    KIND_BAD     = 3'd3,
    KIND_ABORT   = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_LEN_HI  = 3'd1,
    PH_LEN_LO  = 3'd2,
    PH_ID      = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CRC     = 3'd5
  } phase_e;

  typedef enum logic {
    OP_BYTE    = 1'b0,
    OP_TIMEOUT = 1'b1
  } op_e;

  // Classified item handed from the front to the back.
  typedef struct packed {
    op_e        op;
    logic [7:0] data;
  } item_t;

  // Queue handshake between front and back.
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_out_t;

  // One byte through the reflected CRC-32 register.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  // CRC register after the eight sync bytes, folded at elaboration.
  function automatic logic [31:0] sync_crc();
    logic [31:0] c;
    c = CrcInit;
    for (int i = 7; i >= 0; i--) begin
      c = crc_byte(c, SyncWord[i*8 +: 8]);
    end
    return c;
  endfunction

  localparam logic [31:0] CrcAfterSync = sync_crc();

endpackage

FILE: hw/rtl/swd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swd_in_if / swd_out_if
// Valid/ready channels carrying received items and deframer results.
// ----------------------------------------------------------------------------
interface swd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       timeout;

  modport source (output valid, rx_byte, timeout, input ready);
  modport sink   (input valid, rx_byte, timeout, output ready);
endinterface

interface swd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  out_kind;
  logic [7:0]  out_byte;
  logic [7:0]  frame_id;
  logic [15:0] payload_length;
  logic        frame_last;

  modport source (output valid, out_kind, out_byte, frame_id, payload_length, frame_last,
                  input ready);
  modport sink   (input valid, out_kind, out_byte, frame_id, payload_length, frame_last,
                  output ready);
endinterface

FILE: hw/rtl/swd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swd_front
// Accepts input items, tags them as byte or timeout and queues them.
// ----------------------------------------------------------------------------
module swd_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  swd_in_if.sink                in_i,
  output swd_pkg::queue_out_t   q_o,
  input  logic                  q_pop_i
);

  swd_pkg::item_t                    mem_q [swd_pkg::QueueDepth];
  logic [swd_pkg::QueuePtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [swd_pkg::QueuePtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [swd_pkg::QueueCntW-1:0]     cnt_q, cnt_d;
  logic                              push, pop;
  swd_pkg::item_t                    item_in;

  assign in_i.ready = (cnt_q != swd_pkg::QueueCntW'(swd_pkg::QueueDepth));
  assign push       = in_i.valid && in_i.ready;
  assign pop        = q_pop_i && (cnt_q != '0);

  always_comb begin
    item_in.op   = in_i.timeout ? swd_pkg::OP_TIMEOUT : swd_pkg::OP_BYTE;
    item_in.data = in_i.rx_byte;
  end

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + swd_pkg::QueueCntW'(push) - swd_pkg::QueueCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

  assign q_o.valid = (cnt_q != '0);
  assign q_o.item  = mem_q[rd_ptr_q];

endmodule

FILE: hw/rtl/swd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swd_back
// Frame state machine with running CRC-32 and a registered result stage.
// ----------------------------------------------------------------------------
module swd_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  swd_pkg::queue_out_t   q_i,
  output logic                  q_pop_o,
  swd_out_if.source             out_o
);

  swd_pkg::phase_e phase_q, phase_d;
  logic [63:0]     window_q, window_d;
  logic [15:0]     length_q, length_d;
  logic [15:0]     count_q, count_d;
  logic [7:0]      id_q, id_d;
  logic [31:0]     crc_q, crc_d;
  logic [31:0]     crc_rx_q, crc_rx_d;

  logic [31:0]     crc_step;
  logic [15:0]     count_inc;
  logic [63:0]     window_shift;
  logic            step;
  logic            is_to;
  logic [7:0]      b;

  logic            res_emit;
  swd_pkg::kind_e  res_kind;
  logic [7:0]      res_byte;
  logic            res_last;

  logic            out_valid_q;
  swd_pkg::kind_e  out_kind_q;
  logic [7:0]      out_byte_q;
  logic [7:0]      out_id_q;
  logic [15:0]     out_len_q;
  logic            out_last_q;

  // Take the next item when the result stage is free or draining.
  assign step    = q_i.valid && (!out_valid_q || out_o.ready);
  assign q_pop_o = step;
  assign is_to   = (q_i.item.op == swd_pkg::OP_TIMEOUT);
  assign b       = q_i.item.data;

  assign crc_step     = swd_pkg::crc_byte(crc_q, b);
  assign count_inc    = count_q + 16'd1;
  assign window_shift = {window_q[55:0], b};

  // Next state.
  always_comb begin
    phase_d  = phase_q;
    window_d = window_q;
    length_d = length_q;
    count_d  = count_q;
    id_d     = id_q;
    crc_d    = crc_q;
    crc_rx_d = crc_rx_q;
    if (step) begin
      if (is_to) begin
        phase_d  = swd_pkg::PH_HUNT;
        window_d = '0;
        crc_d    = swd_pkg::CrcInit;
      end else begin
        unique case (phase_q)
          swd_pkg::PH_LEN_HI: begin
            crc_d    = crc_step;
            length_d = {b, 8'd0};
            phase_d  = swd_pkg::PH_LEN_LO;
          end
          swd_pkg::PH_LEN_LO: begin
            crc_d    = crc_step;
            length_d = {length_q[15:8], b};
            phase_d  = swd_pkg::PH_ID;
          end
          swd_pkg::PH_ID: begin
            crc_d   = crc_step;
            id_d    = b;
            count_d = '0;
            phase_d = (length_q == '0) ? swd_pkg::PH_CRC : swd_pkg::PH_PAYLOAD;
          end
          swd_pkg::PH_PAYLOAD: begin
            crc_d = crc_step;
            if (count_inc >= length_q) begin
              count_d = '0;
              phase_d = swd_pkg::PH_CRC;
            end else begin
              count_d = count_inc;
            end
          end
          swd_pkg::PH_CRC: begin
            crc_rx_d = {crc_rx_q[23:0], b};
            if (count_inc >= swd_pkg::CrcBytes) begin
              count_d  = '0;
              phase_d  = swd_pkg::PH_HUNT;
              window_d = '0;
              crc_d    = swd_pkg::CrcInit;
            end else begin
              count_d = count_inc;
            end
          end
          default: begin
            phase_d  = swd_pkg::PH_HUNT;
            window_d = window_shift;
            if (window_shift == swd_pkg::SyncWord) begin
              crc_d    = swd_pkg::CrcAfterSync;
              length_d = '0;
              id_d     = '0;
              count_d  = '0;
              crc_rx_d = '0;
              phase_d  = swd_pkg::PH_LEN_HI;
            end
          end
        endcase
      end
    end
  end

  // Result of the current item.
  always_comb begin
    res_emit = 1'b0;
    res_kind = swd_pkg::KIND_HEADER;
    res_byte = '0;
    res_last = 1'b0;
    if (step) begin
      if (is_to) begin
        if (phase_q != swd_pkg::PH_HUNT) begin
          res_emit = 1'b1;
          res_kind = swd_pkg::KIND_ABORT;
          res_last = 1'b1;
        end
      end else begin
        unique case (phase_q)
          swd_pkg::PH_ID: begin
            res_emit = 1'b1;
            res_kind = swd_pkg::KIND_HEADER;
          end
          swd_pkg::PH_PAYLOAD: begin
            res_emit = 1'b1;
            res_kind = swd_pkg::KIND_PAYLOAD;
            res_byte = b;
          end
          swd_pkg::PH_CRC: begin
            if (count_inc >= swd_pkg::CrcBytes) begin
              res_emit = 1'b1;
              res_last = 1'b1;
              res_kind = (~crc_q == {crc_rx_q[23:0], b}) ? swd_pkg::KIND_GOOD
                                                         : swd_pkg::KIND_BAD;
            end
          end
          default: begin
            res_emit = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= swd_pkg::PH_HUNT;
      window_q    <= '0;
      length_q    <= '0;
      count_q     <= '0;
      id_q        <= '0;
      crc_q       <= swd_pkg::CrcInit;
      crc_rx_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      window_q <= window_d;
      length_q <= length_d;
      count_q  <= count_d;
      id_q     <= id_d;
      crc_q    <= crc_d;
      crc_rx_q <= crc_rx_d;
      if (res_emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_emit) begin
      out_kind_q <= res_kind;
      out_byte_q <= res_byte;
      out_id_q   <= id_d;
      out_len_q  <= length_d;
      out_last_q <= res_last;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.out_kind       = out_kind_q;
  assign out_o.out_byte       = out_byte_q;
  assign out_o.frame_id       = out_id_q;
  assign out_o.payload_length = out_len_q;
  assign out_o.frame_last     = out_last_q;

endmodule

FILE: hw/rtl/sync_word_packet_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_word_packet_deframer
// Hunts for a 64-bit sync word in a byte stream and unpacks length/id framed
// packets with a trailing CRC-32.
// ----------------------------------------------------------------------------
// The block takes one item per clock on in_i while out_o keeps up: a received
// byte or a timeout. Items enter a two-entry queue in the front and the back
// consumes one per cycle while its result register is free or being taken,
// running the frame state machine and a combinational CRC-32 byte step. The
// back registers a result as it pops the item and out_o takes it from there;
// the result register accepts a new entry in the cycle the old one is taken.
// While hunting, bytes slide through an 8-byte window until it reads
// DE AD BE EF CA FE BA BE. After that: big-endian 16-bit length, id byte,
// payload, big-endian CRC-32 (reflected, poly EDB88320, init all ones, final
// inversion) over sync word, length, id and payload. Results: one header after
// the id, one per payload byte, then good or bad CRC with frame_last set. A
// timeout mid-frame yields an abort with frame_last set; any timeout clears the
// window and restarts hunting. Overlapping sync words are not searched.
// ----------------------------------------------------------------------------
module sync_word_packet_deframer (
  input  logic       clk_i,
  input  logic       rst_ni,
  swd_in_if.sink     in_i,
  swd_out_if.source  out_o
);

  // Classified items waiting for the frame engine.
  swd_pkg::queue_out_t q_head;
  logic                q_pop;

  // Front: accept and tag items, hold them until the back can take them.
  swd_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .q_o     (q_head),
    .q_pop_i (q_pop)
  );

  // Back: advance the frame state, update the CRC, register results.
  swd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .q_i     (q_head),
    .q_pop_o (q_pop),
    .out_o   (out_o)
  );

endmodule

FILE: tb/sv/tb_sync_word_packet_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sync_word_packet_deframer
// Self-checking bench: byte/timeout items in, header/payload/CRC results out.
// A directed table runs first: hunt timeout, abort on a half-read length, and
// a zero-length frame with a good CRC. Then random frames follow: noise, partial
// sync words, small and huge lengths, corrupted CRCs and timeouts at any point.
// A cycle-free model of the frame parser predicts every result. Both channels
// idle at random.
// ----------------------------------------------------------------------------
module tb_sync_word_packet_deframer;
  import swd_pkg::*;

  localparam int unsigned DirRows     = 26;
  localparam int unsigned RandItems   = 340;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned MaxReports  = 10;
  localparam longint      RunLimitNs  = 2_000_000;

  // Own copies of the framing constants; the package helpers are not reused.
  localparam logic [63:0] SyncPattern = 64'hDEAD_BEEF_CAFE_BABE;
  localparam logic [31:0] Crc32Init   = 32'hFFFF_FFFF;
  localparam logic [31:0] Crc32Poly   = 32'hEDB8_8320;

  // How a directed row is checked.
  typedef enum logic [1:0] {
    CHK_NONE  = 2'd0,   // no result may come from this item
    CHK_MODEL = 2'd1,   // take whatever the frame model predicts
    CHK_GIVEN = 2'd2    // result is typed into the row
  } check_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic [7:0]  id;
    logic [15:0] len;
    logic        last;
  } frame_result_t;

  typedef struct packed {
    op_e           op;
    logic [7:0]    data;
    logic          crc_fill;  // replace data with the correct CRC byte
    check_e        how;
    frame_result_t want;
  } dir_row_t;

  localparam frame_result_t NoResult = '{KIND_HEADER, 8'h00, 8'h00, 16'h0000, 1'b0};

  // Directed table: a timeout while hunting, an abort after the length high
  // byte, then a zero-length frame whose CRC closes good.
  localparam dir_row_t DirTable [DirRows] = '{
    '{OP_TIMEOUT, 8'hFF, 1'b0, CHK_NONE,  NoResult},
    '{OP_BYTE,    8'hDE, 1'b0, CHK_NONE,  NoResult},
    '{OP_BYTE,    8'hAD, 1'b0, CHK_NONE,  NoResult},
    '{OP_BYTE,    8'hBE, 1'b0, CHK_NONE,  NoResult},
    '{OP_BYTE,    8'hEF, 1'b0, CHK_NONE,  NoResult},
    '{OP_BYTE,    8'hCA, 1'b0, CHK_NONE,  NoResult},
    '{OP_BYTE,    8'hFE, 1'b0, CHK_NONE,  NoResult},
    '{OP_BYTE,    8'hBA, 1'b0, CHK_NONE,  NoResult},
    '{OP_BYTE,    8'hBE, 1'b0, CHK_NONE,  NoResult},
    '{OP_BYTE,    8'hFF, 1'b0, CHK_NONE,  NoResult},
    '{OP_TIMEOUT, 8'h00, 1'b0, CHK_GIVEN, '{KIND_ABORT, 8'h00, 8'h00, 16'hFF00, 1'b1}},
    '{OP_BYTE,    8'hDE, 1'b0, CHK_NONE,  NoResult},
    '{OP_BYTE,    8'hAD, 1'b0, CHK_NONE,  NoResult},
    '{OP_BYTE,    8'hBE, 1'b0, CHK_NONE,  NoResult},
    '{OP_BYTE,    8'hEF, 1'b0, CHK_NONE,  NoResult},
    '{OP_BYTE,    8'hCA, 1'b0, CHK_NONE,  NoResult},
    '{OP_BYTE,    8'hFE, 1'b0, CHK_NONE,  NoResult},
    '{OP_BYTE,    8'hBA, 1'b0, CHK_NONE,  NoResult},
    '{OP_BYTE,    8'hBE, 1'b0, CHK_NONE,  NoResult},
    '{OP_BYTE,    8'h00, 1'b0, CHK_NONE,  NoResult},
    '{OP_BYTE,    8'h00, 1'b0, CHK_NONE,  NoResult},
    '{OP_BYTE,    8'hFF, 1'b0, CHK_GIVEN, '{KIND_HEADER, 8'h00, 8'hFF, 16'h0000, 1'b0}},
    '{OP_BYTE,    8'h00, 1'b1, CHK_NONE,  NoResult},
    '{OP_BYTE,    8'h00, 1'b1, CHK_NONE,  NoResult},
    '{OP_BYTE,    8'h00, 1'b1, CHK_NONE,  NoResult},
    '{OP_BYTE,    8'h00, 1'b1, CHK_GIVEN, '{KIND_GOOD, 8'h00, 8'hFF, 16'h0000, 1'b1}}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  swd_in_if  in_ch ();
  swd_out_if out_ch ();

  sync_word_packet_deframer i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Frame model state, mirroring the parser at item granularity
  // --------------------------------------------------------------------------
  logic [63:0] sync_win  = '0;
  phase_e      cur_phase = PH_HUNT;
  logic [15:0] cur_len   = '0;
  logic [15:0] cur_count = '0;
  logic [7:0]  cur_id    = '0;
  logic [31:0] crc_acc   = Crc32Init;
  logic [31:0] crc_seen  = '0;

  frame_result_t pending_results [$];

  int  err_count    = 0;
  int  n_items      = 0;
  int  n_frame_bytes = 0;
  int  n_results    = 0;
  int  n_kind [5]   = '{default: 0};
  bit  in_calm      = 1'b0;
  bit  out_calm     = 1'b0;

  // Reflected CRC-32, one data bit per step, LSB first.
  function automatic logic [31:0] crc32_next(input logic [31:0] crc, input logic [7:0] d);
    logic [31:0] r;
    r = crc;
    for (int k = 0; k < 8; k++) begin
      r = (r >> 1) ^ ((r[0] ^ d[k]) ? Crc32Poly : 32'h0);
    end
    return r;
  endfunction

  // Next big-endian byte of the frame check sequence the parser waits for.
  function automatic logic [7:0] crc_tail_byte();
    logic [31:0] fcs;
    fcs = ~crc_acc;
    return fcs[8 * (3 - int'(cur_count[1:0])) +: 8];
  endfunction

  function automatic frame_result_t mk_result(input kind_e kind, input logic [7:0] data,
                                              input logic last);
    frame_result_t r;
    r.kind = kind;
    r.data = data;
    r.id   = cur_id;
    r.len  = cur_len;
    r.last = last;
    return r;
  endfunction

  function automatic int draw_wait(input bit calm);
    return calm ? 0 : int'($urandom_range(0, 10));
  endfunction

  task automatic flag_error(input string msg);
    err_count++;
    if (err_count <= MaxReports) $display("ERROR: %s", msg);
  endtask

  // Advance the frame model by one accepted item; hit says a result is due.
  task automatic deframe_predict(input op_e op, input logic [7:0] b,
                                 output bit hit, output frame_result_t res);
    logic [31:0] c;
    kind_e       verdict;
    hit = 1'b0;
    res = NoResult;
    if (op == OP_TIMEOUT) begin
      // Abort only when a frame is open; always restart hunting from scratch.
      if (cur_phase != PH_HUNT) begin
        hit = 1'b1;
        res = mk_result(KIND_ABORT, 8'h00, 1'b1);
      end
      sync_win  = '0;
      cur_phase = PH_HUNT;
      crc_acc   = Crc32Init;
    end else begin
      case (cur_phase)
        PH_LEN_HI: begin
          crc_acc   = crc32_next(crc_acc, b);
          cur_len   = {b, 8'h00};
          cur_phase = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          crc_acc      = crc32_next(crc_acc, b);
          cur_len[7:0] = b;
          cur_phase    = PH_ID;
        end
        PH_ID: begin
          crc_acc   = crc32_next(crc_acc, b);
          cur_id    = b;
          cur_count = '0;
          // Zero length skips straight to the CRC bytes.
          cur_phase = (cur_len == 16'd0) ? PH_CRC : PH_PAYLOAD;
          hit       = 1'b1;
          res       = mk_result(KIND_HEADER, 8'h00, 1'b0);
        end
        PH_PAYLOAD: begin
          crc_acc   = crc32_next(crc_acc, b);
          cur_count = cur_count + 16'd1;
          if (cur_count >= cur_len) begin
            cur_count = '0;
            cur_phase = PH_CRC;
          end
          hit = 1'b1;
          res = mk_result(KIND_PAYLOAD, b, 1'b0);
        end
        PH_CRC: begin
          crc_seen  = {crc_seen[23:0], b};
          cur_count = cur_count + 16'd1;
          if (cur_count >= 16'd4) begin
            verdict   = ((~crc_acc) == crc_seen) ? KIND_GOOD : KIND_BAD;
            hit       = 1'b1;
            res       = mk_result(verdict, 8'h00, 1'b1);
            cur_count = '0;
            sync_win  = '0;
            cur_phase = PH_HUNT;
            crc_acc   = Crc32Init;
          end
        end
        default: begin
          // Hunt: slide the window, lock on an exact sync word match.
          cur_phase = PH_HUNT;
          sync_win  = {sync_win[55:0], b};
          if (sync_win == SyncPattern) begin
            c = Crc32Init;
            for (int i = 7; i >= 0; i--) c = crc32_next(c, SyncPattern[8 * i +: 8]);
            crc_acc   = c;
            cur_len   = '0;
            cur_id    = '0;
            cur_count = '0;
            crc_seen  = '0;
            cur_phase = PH_LEN_HI;
          end
        end
      endcase
    end
  endtask

  // --------------------------------------------------------------------------
  // Input side: one item per call, called in the step its predecessor was
  // accepted so valid gets a single update per edge.
  // --------------------------------------------------------------------------
  task automatic push_item(input op_e op, input logic [7:0] b, input bit drain,
                           input check_e how, input frame_result_t given);
    int            gap;
    bit            hit;
    frame_result_t pred;
    gap = draw_wait(in_calm);
    if (drain || gap > 0) begin
      in_ch.valid <= 1'b0;
      // Hold off until every result owed so far has come out.
      if (drain) begin
        while (pending_results.size() != 0) @(posedge clk_i);
        @(posedge clk_i);
      end
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid   <= 1'b1;
    in_ch.timeout <= op;
    in_ch.rx_byte <= b;
    do @(posedge clk_i); while (!in_ch.ready);

    // Accepted at this edge: advance the model and book the expectation.
    deframe_predict(op, b, hit, pred);
    n_items++;
    case (how)
      CHK_MODEL: if (hit) pending_results = {pending_results, pred};
      CHK_GIVEN: pending_results = {pending_results, given};
      default: ;
    endcase
    if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
  endtask

  // --------------------------------------------------------------------------
  // Output side: compare each taken result with the oldest expectation.
  // --------------------------------------------------------------------------
  task automatic take_result();
    frame_result_t got;
    frame_result_t want;
    got.kind = kind_e'(out_ch.out_kind);
    got.data = out_ch.out_byte;
    got.id   = out_ch.frame_id;
    got.len  = out_ch.payload_length;
    got.last = out_ch.frame_last;
    n_results++;
    if (!$isunknown(out_ch.out_kind) && out_ch.out_kind <= 3'd4) n_kind[out_ch.out_kind]++;
    if (pending_results.size() == 0) begin
      flag_error($sformatf("unexpected result kind %0d byte %02h id %02h len %04h last %0b",
                           got.kind, got.data, got.id, got.len, got.last));
      return;
    end
    want = pending_results.pop_front();
    if (got.kind !== want.kind || got.data !== want.data || got.id !== want.id ||
        got.len !== want.len || got.last !== want.last) begin
      flag_error($sformatf({"result %0d: kind %0d/%0d byte %02h/%02h id %02h/%02h ",
                            "len %04h/%04h last %0b/%0b (got/exp)"},
                           n_results, got.kind, want.kind, got.data, want.data,
                           got.id, want.id, got.len, want.len, got.last, want.last));
    end
  endtask

  initial begin : result_sink
    int stall;
    out_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = draw_wait(out_calm);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (out_ch.valid !== 1'b1);
      take_result();
      if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [7:0]  frame_bytes [$];
    logic [7:0]  b;
    logic [15:0] len;
    logic [7:0]  id;
    int          n_noise;
    int          k;
    int          pick;
    int          pay_n;
    int          total;
    int          abort_at;
    int          flip_at;
    bit          drain;
    bit          huge;

    rst_ni        <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.rx_byte <= 8'h00;
    in_ch.timeout <= OP_BYTE;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table; CRC rows take the byte the parser needs.
    for (int r = 0; r < DirRows; r++) begin
      b = DirTable[r].crc_fill ? crc_tail_byte() : DirTable[r].data;
      push_item(DirTable[r].op, b, 1'b0, DirTable[r].how, DirTable[r].want);
    end

    // Random frames; the first one waits for the directed results to drain.
    drain = 1'b1;
    while (n_frame_bytes < RandItems) begin
      // Line noise and stray timeouts while hunting.
      n_noise = $urandom_range(0, 3);
      repeat (n_noise) begin
        push_item(($urandom_range(0, 9) == 0) ? OP_TIMEOUT : OP_BYTE,
                  8'($urandom_range(0, 255)), 1'b0, CHK_MODEL, NoResult);
      end
      // Sometimes a sync word cut short just ahead of the real one.
      if ($urandom_range(0, 9) == 0) begin
        k = $urandom_range(1, 7);
        for (int i = 0; i < k; i++) begin
          push_item(OP_BYTE, SyncPattern[63 - 8 * i -: 8], 1'b0, CHK_MODEL, NoResult);
        end
      end

      // Mostly short frames, a few long ones, and rare huge lengths that get
      // aborted at most 30 payload bytes in.
      pick = $urandom_range(0, 99);
      huge = 1'b0;
      if (pick < 15)      len = 16'd0;
      else if (pick < 75) len = 16'($urandom_range(1, 8));
      else if (pick < 93) len = 16'($urandom_range(9, 48));
      else begin
        len  = 16'($urandom_range(256, 65535));
        huge = 1'b1;
      end
      id    = 8'($urandom_range(0, 255));
      pay_n = huge ? $urandom_range(0, 30) : int'(len);

      frame_bytes.delete();
      for (int i = 0; i < 8; i++) frame_bytes = {frame_bytes, SyncPattern[63 - 8 * i -: 8]};
      frame_bytes = {frame_bytes, len[15:8]};
      frame_bytes = {frame_bytes, len[7:0]};
      frame_bytes = {frame_bytes, id};
      repeat (pay_n) frame_bytes = {frame_bytes, 8'($urandom_range(0, 255))};
      total = frame_bytes.size() + 4;

      abort_at = -1;
      flip_at  = -1;
      if (huge) abort_at = frame_bytes.size();
      else if ($urandom_range(0, 99) < 15) abort_at = $urandom_range(0, total - 1);
      else if ($urandom_range(0, 99) < 20) flip_at = $urandom_range(total - 4, total - 1);

      for (int i = 0; i < total; i++) begin
        if (i == abort_at) begin
          push_item(OP_TIMEOUT, 8'($urandom_range(0, 255)), drain, CHK_MODEL, NoResult);
          n_frame_bytes++;
          break;
        end
        b = (i < frame_bytes.size()) ? frame_bytes[i] : crc_tail_byte();
        // Corrupt one CRC byte by a single bit.
        if (i == flip_at) b = b ^ (8'h01 << $urandom_range(0, 7));
        push_item(OP_BYTE, b, drain, CHK_MODEL, NoResult);
        drain = 1'b0;
        n_frame_bytes++;
      end
      if ($urandom_range(0, 19) == 0) drain = 1'b1;
    end
    in_ch.valid <= 1'b0;

    // Wait out every owed result, then idle on to catch strays.
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Run covered %0d items (%0d directed, %0d in random frames), %0d results:",
             n_items, DirRows, n_frame_bytes, n_results);
    $display("  %0d headers, %0d payload bytes, %0d good CRC, %0d bad CRC, %0d aborts",
             n_kind[KIND_HEADER], n_kind[KIND_PAYLOAD], n_kind[KIND_GOOD],
             n_kind[KIND_BAD], n_kind[KIND_ABORT]);
    if (err_count > MaxReports) $display("%0d errors in total", err_count);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Hang guard: far beyond the slowest legal run.
  initial begin : run_limit
    #(RunLimitNs);
    $display("ERROR: run limit reached with %0d results outstanding",
             pending_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/swd_pkg.sv
hw/rtl/swd_if.sv
hw/rtl/swd_front.sv
hw/rtl/swd_back.sv
hw/rtl/sync_word_packet_deframer.sv
tb/sv/tb_sync_word_packet_deframer.sv
